FILE: rtl/core/baft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package baft_pkg;
    localparam int NUM_BLOCKS = 128;
    localparam int NUM_SLOTS = 16;
    localparam int MAX_FILE_BLOCKS = 8;
    localparam int BLK_W = $clog2(NUM_BLOCKS);
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int PTR_IDX_W = $clog2(MAX_FILE_BLOCKS) > 0 ? $clog2(MAX_FILE_BLOCKS) : 1;
    localparam int PTR_ADDR_W = $clog2(NUM_SLOTS * MAX_FILE_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_NO_SLOT = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE = 3'd5;
endpackage
`default_nettype wire

FILE: rtl/core/baft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module baft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/block_allocator_and_file_table.sv
`timescale 1ns / 1ps
`default_nettype none
// file table with a free block map: one command at a time through a small sequencer
// that walks the block map one entry a cycle and the slots one a cycle (delete holds
// the slot walk at a match while its blocks are freed). the free block count is kept
// as a running counter. create finds a free slot, then walks the map from block 1
// taking free blocks; delete visits every slot and frees each matching file's blocks
// by pointer; lookup scans to the first match and then reads the pointer. the pointer
// store is a one-port-write ram with registered read, which sets the per-step cost of
// delete and lookup. no clearing pass.
module block_allocator_and_file_table
    import baft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [63:0] file_name,
    input  wire logic [3:0]  count_or_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [3:0]       slot,
    output logic [6:0]       block_address,
    output logic [4:0]       removed_files
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SLOT  = 9'b000000010,
        S_ALLOC = 9'b000000100,
        S_DSCAN = 9'b000001000,
        S_DRD   = 9'b000010000,
        S_DFREE = 9'b000100000,
        S_LSCAN = 9'b001000000,
        S_LRD   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [NUM_BLOCKS-1:0] in_use_reg, in_use_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [63:0] names_reg [NUM_SLOTS];
    logic [3:0] sizes_reg [NUM_SLOTS];
    logic [CNT_W-1:0] free_reg, free_next;
    logic [63:0] name_reg, name_next;
    logic [3:0] arg_reg, arg_next;
    logic [SLOT_W-1:0] s_reg, s_next;
    logic [BLK_W-1:0] b_reg, b_next;
    logic [4:0] k_reg, k_next;
    logic [4:0] rem_reg, rem_next;
    logic [2:0] st_reg, st_next;
    logic [3:0] osl_reg, osl_next;
    logic [6:0] oad_reg, oad_next;
    logic wr_meta;

    logic ram_we;
    logic [PTR_ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [BLK_W-1:0] ram_wdata, ram_rdata;

    baft_ram #(.WIDTH(BLK_W), .DEPTH(NUM_SLOTS * MAX_FILE_BLOCKS)) u_ptr (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic match;
    logic last_slot;
    assign match = used_reg[s_reg] && (names_reg[s_reg] == name_reg);
    assign last_slot = (s_reg == SLOT_W'(NUM_SLOTS - 1));

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = st_reg;
    assign slot = osl_reg;
    assign block_address = oad_reg;
    assign removed_files = rem_reg;

    always_comb
    begin
        state_next = state_reg;
        in_use_next = in_use_reg;
        used_next = used_reg;
        free_next = free_reg;
        name_next = name_reg;
        arg_next = arg_reg;
        s_next = s_reg;
        b_next = b_reg;
        k_next = k_reg;
        rem_next = rem_reg;
        st_next = st_reg;
        osl_next = osl_reg;
        oad_next = oad_reg;
        wr_meta = 1'b0;
        ram_we = 1'b0;
        ram_waddr = {s_reg, k_reg[PTR_IDX_W-1:0]};
        ram_wdata = b_reg;
        ram_raddr = {s_reg, k_reg[PTR_IDX_W-1:0]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    name_next = file_name;
                    arg_next = count_or_index;
                    s_next = '0;
                    b_next = BLK_W'(1);
                    k_next = '0;
                    rem_next = '0;
                    st_next = ST_OK;
                    osl_next = '0;
                    oad_next = '0;
                    priority if (command == CMD_CREATE)
                    begin
                        if (count_or_index > 4'(MAX_FILE_BLOCKS))
                        begin
                            st_next = ST_BAD_SIZE;
                            state_next = S_OUT;
                        end
                        else if (free_reg < CNT_W'(count_or_index))
                        begin
                            st_next = ST_NO_SPACE;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SLOT;
                        end
                    end
                    else if (command == CMD_DELETE)
                    begin
                        state_next = S_DSCAN;
                    end
                    else if (command == CMD_LOOKUP)
                    begin
                        state_next = S_LSCAN;
                    end
                    else
                    begin
                        st_next = ST_BAD_INDEX;
                        state_next = S_OUT;
                    end
                end
            end
            S_SLOT:
            begin
                if (!used_reg[s_reg])
                begin
                    state_next = S_ALLOC;
                end
                else if (last_slot)
                begin
                    st_next = ST_NO_SLOT;
                    state_next = S_OUT;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            S_ALLOC:
            begin
                if (k_reg == 5'(arg_reg))
                begin
                    used_next[s_reg] = 1'b1;
                    wr_meta = 1'b1;
                    free_next = free_reg - CNT_W'(arg_reg);
                    osl_next = 4'(s_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    if (!in_use_reg[b_reg])
                    begin
                        in_use_next[b_reg] = 1'b1;
                        ram_we = 1'b1;
                        k_next = k_reg + 1'b1;
                    end
                    b_next = b_reg + 1'b1;
                end
            end
            S_DSCAN:
            begin
                k_next = '0;
                if (match)
                begin
                    used_next[s_reg] = 1'b0;
                    rem_next = rem_reg + 1'b1;
                    state_next = S_DRD;
                end
                else if (last_slot)
                begin
                    st_next = (rem_reg == 5'd0) ? ST_NOT_FOUND : ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            S_DRD:
            begin
                if (k_reg >= 5'(sizes_reg[s_reg]) || k_reg >= 5'(MAX_FILE_BLOCKS))
                begin
                    if (last_slot)
                    begin
                        st_next = ST_OK;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        s_next = s_reg + 1'b1;
                        state_next = S_DSCAN;
                    end
                end
                else
                begin
                    state_next = S_DFREE;
                end
            end
            S_DFREE:
            begin
                if (in_use_reg[ram_rdata])
                begin
                    free_next = free_reg + 1'b1;
                end
                in_use_next[ram_rdata] = 1'b0;
                k_next = k_reg + 1'b1;
                state_next = S_DRD;
            end
            S_LSCAN:
            begin
                ram_raddr = {s_reg, arg_reg[PTR_IDX_W-1:0]};
                if (match)
                begin
                    if (arg_reg >= sizes_reg[s_reg] || 5'(arg_reg) >= 5'(MAX_FILE_BLOCKS))
                    begin
                        st_next = ST_BAD_INDEX;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_LRD;
                    end
                end
                else if (last_slot)
                begin
                    st_next = ST_NOT_FOUND;
                    state_next = S_OUT;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            S_LRD:
            begin
                osl_next = 4'(s_reg);
                oad_next = 7'(ram_rdata);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_use_reg <= '0;
            used_reg <= '0;
            free_reg <= CNT_W'(NUM_BLOCKS - 1);
        end
        else
        begin
            state_reg <= state_next;
            in_use_reg <= in_use_next;
            used_reg <= used_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_reg <= name_next;
        arg_reg <= arg_next;
        s_reg <= s_next;
        b_reg <= b_next;
        k_reg <= k_next;
        rem_reg <= rem_next;
        st_reg <= st_next;
        osl_reg <= osl_next;
        oad_reg <= oad_next;
        if (wr_meta)
        begin
            names_reg[s_reg] <= name_reg;
            sizes_reg[s_reg] <= arg_reg;
        end
    end
endmodule
`default_nettype wire

FILE: tb/block_allocator_and_file_table_test.sv
`timescale 1ns / 1ps
module block_allocator_and_file_table_test;
    import baft_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [6:0] block_address;
        logic [4:0] removed_files;
    } file_reply_t;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 20000;

    class file_table_scoreboard;
        bit          block_in_use[NUM_BLOCKS];
        bit          slot_used[NUM_SLOTS];
        logic [63:0] slot_name[NUM_SLOTS];
        int          slot_size[NUM_SLOTS];
        int          slot_ptr[NUM_SLOTS][MAX_FILE_BLOCKS];
        file_reply_t pending_replies[$];
        int          mismatches;

        function void note_transaction(logic [1:0] cmd, logic [63:0] name, logic [3:0] arg);
            file_reply_t r;
            int free_cnt;
            int s;
            int k;
            int removed;
            r = '0;
            s = -1;
            free_cnt = 0;
            removed = 0;
            case (cmd)
                CMD_CREATE:
                begin
                    for (int b = 1; b < NUM_BLOCKS; b++)
                        if (!block_in_use[b]) free_cnt++;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (s < 0 && !slot_used[i]) s = i;
                    if (arg > MAX_FILE_BLOCKS) r.status = ST_BAD_SIZE;
                    else if (free_cnt < arg) r.status = ST_NO_SPACE;
                    else if (s < 0) r.status = ST_NO_SLOT;
                    else
                    begin
                        k = 0;
                        for (int b = 1; b < NUM_BLOCKS && k < arg; b++)
                            if (!block_in_use[b])
                            begin
                                block_in_use[b] = 1;
                                slot_ptr[s][k] = b;
                                k++;
                            end
                        slot_used[s] = 1;
                        slot_name[s] = name;
                        slot_size[s] = arg;
                        r.status = ST_OK;
                        r.slot = 4'(s);
                    end
                end
                CMD_DELETE:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (slot_used[i] && slot_name[i] == name)
                        begin
                            for (int j = 0; j < slot_size[i]; j++)
                                block_in_use[slot_ptr[i][j]] = 0;
                            slot_used[i] = 0;
                            removed++;
                        end
                    r.status = removed ? ST_OK : ST_NOT_FOUND;
                    r.removed_files = 5'(removed);
                end
                CMD_LOOKUP:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (s < 0 && slot_used[i] && slot_name[i] == name) s = i;
                    if (s < 0) r.status = ST_NOT_FOUND;
                    else if (arg >= slot_size[s]) r.status = ST_BAD_INDEX;
                    else
                    begin
                        r.status = ST_OK;
                        r.slot = 4'(s);
                        r.block_address = 7'(slot_ptr[s][arg]);
                    end
                end
                default: r.status = ST_BAD_INDEX;
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_reply(file_reply_t got);
            file_reply_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reply %h", got);
                return;
            end
            want = pending_replies.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected st=%0d sl=%0d addr=%0d rem=%0d, %s",
                        want.status, want.slot, want.block_address, want.removed_files,
                        $sformatf("got st=%0d sl=%0d addr=%0d rem=%0d",
                        got.status, got.slot, got.block_address, got.removed_files));
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [63:0] file_name = '0;
    logic [3:0]  count_or_index = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [6:0]  block_address;
    logic [4:0]  removed_files;

    file_table_scoreboard board = new();
    int  quiet_cycles = 0;
    bit  calm = 0;
    logic [63:0] name_pool[8];

    block_allocator_and_file_table dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_reply('{status, slot, block_address, removed_files});
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);

    task automatic send_request(logic [1:0] cmd, logic [63:0] name, logic [3:0] arg);
        if (!calm)
            while ($urandom_range(99) < 12)
            begin
                in_valid <= 0;
                @(negedge clk);
            end
        in_valid <= 1;
        command <= cmd;
        file_name <= name;
        count_or_index <= arg;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_transaction(cmd, name, arg);
        @(negedge clk);
    endtask

    task automatic drain_replies();
        in_valid <= 0;
        while (board.pending_replies.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        logic [1:0] c;
        int pick;
        logic [63:0] nm;
        for (int i = 0; i < 8; i++) name_pool[i] = {$urandom, $urandom};
        name_pool[0] = '0;
        name_pool[1] = '1;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_request(CMD_LOOKUP, name_pool[2], 0);
        send_request(CMD_DELETE, name_pool[2], 0);
        send_request(CMD_CREATE, name_pool[2], 9);
        send_request(CMD_CREATE, name_pool[2], 15);
        send_request(CMD_CREATE, name_pool[0], 0);
        send_request(CMD_CREATE, name_pool[1], 8);
        send_request(CMD_CREATE, name_pool[1], 3);
        send_request(CMD_LOOKUP, name_pool[1], 7);
        send_request(CMD_LOOKUP, name_pool[1], 0);
        send_request(CMD_LOOKUP, name_pool[1], 8);
        send_request(CMD_LOOKUP, name_pool[1], 15);
        send_request(CMD_LOOKUP, name_pool[0], 0);
        send_request(CMD_UNKNOWN, name_pool[1], 15);
        send_request(CMD_DELETE, name_pool[1], 0);
        send_request(CMD_DELETE, name_pool[0], 0);
        for (int i = 0; i < 17; i++) send_request(CMD_CREATE, name_pool[3], 8);
        send_request(CMD_CREATE, name_pool[4], 1);
        send_request(CMD_DELETE, name_pool[3], 0);
        drain_replies();

        for (int n = 0; n < 1900; n++)
        begin
            calm = (n >= 600 && n < 900);
            if (n == 1200) drain_replies();
            pick = $urandom_range(99);
            nm = ($urandom_range(9) == 0) ? {$urandom, $urandom} : name_pool[$urandom_range(7)];
            if (pick < 40) c = CMD_CREATE;
            else if (pick < 60) c = CMD_DELETE;
            else if (pick < 97) c = CMD_LOOKUP;
            else c = CMD_UNKNOWN;
            if (c == CMD_CREATE && $urandom_range(9) != 0)
                send_request(c, nm, 4'($urandom_range(MAX_FILE_BLOCKS)));
            else if (c == CMD_LOOKUP && $urandom_range(4) != 0)
                send_request(c, nm, 4'($urandom_range(MAX_FILE_BLOCKS - 1)));
            else
                send_request(c, nm, 4'($urandom_range(15)));
        end
        calm = 0;
        drain_replies();
        repeat (400) @(negedge clk);
        if (board.mismatches == 0 && board.pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
